// ===== rtl/core/tds_pkg.sv =====
// Shared types and codes for the timer deadline scheduler.
`timescale 1ns / 1ps
package tds_pkg;

  localparam int unsigned IdW = 6;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_STOP    = 3'd1,
    OP_AGAIN   = 3'd2,
    OP_REMAIN  = 3'd3,
    OP_ADVANCE = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    K_DONE    = 3'd0,
    K_EXPIRED = 3'd1,
    K_REMAIN  = 3'd2,
    K_REFUSED = 3'd3,
    K_FINISH  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    C_NONE   = 3'd0,
    C_START  = 3'd1,
    C_STOP   = 3'd2,
    C_AGAIN  = 3'd3,
    C_REMAIN = 3'd4,
    C_EXPIRE = 3'd5
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_OP   = 2'd1,
    S_SCAN = 2'd2
  } state_e;

  typedef struct packed {
    cell_op_e         op;
    logic [IdW-1:0]   id;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
  } tok_t;

endpackage

// ===== rtl/core/tds_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface tds_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  timer_id;
  logic [31:0] delay;
  logic [31:0] period;
  logic [31:0] now;
  modport source (output valid, opcode, timer_id, delay, period, now, input ready);
  modport sink   (input valid, opcode, timer_id, delay, period, now, output ready);
endinterface

interface tds_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  timer_id_out;
  logic [31:0] time_left;
  logic        last;
  modport source (output valid, kind, timer_id_out, time_left, last, input ready);
  modport sink   (input valid, kind, timer_id_out, time_left, last, output ready);
endinterface

// ===== rtl/core/tds_cell.sv =====
// One timer cell: holds a timer's state and passes the earliest-due token on.
`timescale 1ns / 1ps
module tds_cell #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned CELL_ID   = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tds_pkg::cmd_t          cmd_i,
  input  logic [TIME_BITS-1:0]   cur_i,
  input  logic [TIME_BITS-1:0]   delay_i,
  input  logic [TIME_BITS-1:0]   period_i,
  input  tds_pkg::tok_t          tok_i,
  input  logic [TIME_BITS-1:0]   tok_dl_i,
  output tds_pkg::tok_t          tok_o,
  output logic [TIME_BITS-1:0]   tok_dl_o,
  output tds_pkg::kind_e         kind_o,
  output logic [TIME_BITS-1:0]   left_o
);
  import tds_pkg::*;

  localparam logic [TIME_BITS-1:0] TMax = '1;

  logic                 active_q, active_d;
  logic [TIME_BITS-1:0] dl_q, dl_d, per_q, per_d;
  tok_t                 tok_q, tok_d;
  logic [TIME_BITS-1:0] tok_dl_q, tok_dl_d;
  logic                 sel, due;
  logic [TIME_BITS-1:0] nxt;

  assign sel = (cmd_i.id == IdW'(CELL_ID));
  assign due = active_q && (dl_q <= cur_i);

  always_comb begin
    active_d = active_q;
    dl_d     = dl_q;
    per_d    = per_q;
    kind_o   = K_DONE;
    left_o   = '0;
    nxt      = dl_q + per_q;
    if (sel) begin
      case (cmd_i.op)
        C_START: begin
          if (!active_q && delay_i <= TMax - cur_i) begin
            active_d = 1'b1;
            dl_d     = cur_i + delay_i;
            per_d    = period_i;
          end else begin
            kind_o = K_REFUSED;
          end
        end
        C_STOP: active_d = 1'b0;
        C_AGAIN: begin
          if (active_q) begin
            if (per_q == '0 || cur_i >= TMax - per_q) active_d = 1'b0;
            else dl_d = cur_i + per_q;
          end else if (per_q != '0) begin
            if (per_q <= TMax - cur_i) begin
              active_d = 1'b1;
              dl_d     = cur_i + per_q;
            end else begin
              kind_o = K_REFUSED;
            end
          end
        end
        C_REMAIN: begin
          kind_o = K_REMAIN;
          if (active_q && dl_q > cur_i) left_o = dl_q - cur_i;
        end
        C_EXPIRE: begin
          kind_o = K_EXPIRED;
          if (per_q == '0 || dl_q >= TMax - per_q) begin
            active_d = 1'b0;
          end else if (nxt <= cur_i) begin
            // periodic timer fell behind: clamp to one tick after now
            if (cur_i == TMax) active_d = 1'b0;
            else dl_d = cur_i + 1'b1;
          end else begin
            dl_d = nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // strict compare keeps the lower id on equal deadlines
  always_comb begin
    tok_d    = tok_i;
    tok_dl_d = tok_dl_i;
    if (due && (!tok_i.valid || dl_q < tok_dl_i)) begin
      tok_d.valid = 1'b1;
      tok_d.id    = IdW'(CELL_ID);
      tok_dl_d    = dl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      per_q    <= '0;
      tok_q    <= '0;
    end else begin
      active_q <= active_d;
      per_q    <= per_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q     <= dl_d;
    tok_dl_q <= tok_dl_d;
  end

  assign tok_o    = tok_q;
  assign tok_dl_o = tok_dl_q;

endmodule

// ===== rtl/core/timer_deadline_scheduler_unit.sv =====
// Top level of the timer deadline scheduler: control sequencer and cell chain.
`timescale 1ns / 1ps
// Deadline-ordered timer queue. Each timer lives in a cell of a chain; an
// earliest-due token ripples through the chain one cell per cycle. A start,
// stop, again or remaining request is registered on transfer, and its result
// is registered from the op state. An advance sweeps the whole cell chain
// once per expired timer and once more before its closing finish result.
// One request is in service at a time; result-side stalls lengthen its service.
module timer_deadline_scheduler_unit #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tds_in_if.sink        req_i,
  tds_out_if.source     rsp_o
);
  import tds_pkg::*;

  localparam int unsigned CntW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned IxW  = $clog2(NUM_TIMERS);

  state_e               state_q, state_d;
  logic [2:0]           op_q;
  logic [3:0]           id_q;
  logic [TIME_BITS-1:0] delay_q, per_q, now_q, cur_q, cur_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  logic                 out_valid_q, out_free, emit;
  logic [2:0]           kind_q, kind_d;
  logic [3:0]           oid_q, oid_d;
  logic [31:0]          left_q, left_d;
  logic                 last_q, last_d;

  cmd_t                 cmd;
  tok_t                 tok   [NUM_TIMERS+1];
  logic [TIME_BITS-1:0] tokdl [NUM_TIMERS+1];
  kind_e                ckind [NUM_TIMERS];
  logic [TIME_BITS-1:0] cleft [NUM_TIMERS];
  logic                 id_ok;

  assign tok[0]   = '0;
  assign tokdl[0] = '0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    tds_cell #(.TIME_BITS(TIME_BITS), .CELL_ID(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .cur_i   (cur_q),
      .delay_i (delay_q),
      .period_i(per_q),
      .tok_i   (tok[g]),
      .tok_dl_i(tokdl[g]),
      .tok_o   (tok[g+1]),
      .tok_dl_o(tokdl[g+1]),
      .kind_o  (ckind[g]),
      .left_o  (cleft[g])
    );
  end

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign id_ok       = (32'(id_q) < 32'(NUM_TIMERS));
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    kind_d   = kind_q;
    oid_d    = oid_q;
    left_d   = '0;
    last_d   = 1'b1;
    cmd.op   = C_NONE;
    cmd.id   = IdW'(id_q);
    case (state_q)
      S_IDLE: if (req_i.valid) state_d = S_OP;
      S_OP: begin
        if (op_q == OP_ADVANCE) begin
          cur_d   = now_q;
          cnt_d   = '0;
          state_d = S_SCAN;
        end else if (out_free) begin
          emit    = 1'b1;
          oid_d   = id_q;
          state_d = S_IDLE;
          if (op_q > OP_ADVANCE || !id_ok) begin
            kind_d = K_REFUSED;
          end else begin
            case (op_q)
              OP_START:  cmd.op = C_START;
              OP_STOP:   cmd.op = C_STOP;
              OP_AGAIN:  cmd.op = C_AGAIN;
              default:   cmd.op = C_REMAIN;
            endcase
            kind_d = ckind[IxW'(id_q)];
            left_d = 32'(cleft[IxW'(id_q)]);
          end
        end
      end
      S_SCAN: begin
        if (cnt_q != CntW'(NUM_TIMERS)) begin
          cnt_d = cnt_q + 1'b1;
        end else if (out_free) begin
          emit = 1'b1;
          if (tok[NUM_TIMERS].valid) begin
            cmd.op = C_EXPIRE;
            cmd.id = tok[NUM_TIMERS].id;
            kind_d = K_EXPIRED;
            oid_d  = 4'(tok[NUM_TIMERS].id);
            last_d = 1'b0;
            cnt_d  = '0;
          end else begin
            kind_d  = K_FINISH;
            oid_d   = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      if (emit) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q    <= req_i.opcode;
      id_q    <= req_i.timer_id;
      delay_q <= TIME_BITS'(req_i.delay);
      per_q   <= TIME_BITS'(req_i.period);
      now_q   <= TIME_BITS'(req_i.now);
    end
    if (emit) begin
      kind_q <= kind_d;
      oid_q  <= oid_d;
      left_q <= left_d;
      last_q <= last_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.kind         = kind_q;
  assign rsp_o.timer_id_out = oid_q;
  assign rsp_o.time_left    = left_q;
  assign rsp_o.last         = last_q;

endmodule

// ===== test/timer_deadline_scheduler_unit_tb.sv =====
// Testbench for the timer deadline scheduler: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module timer_deadline_scheduler_unit_tb;
  import tds_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  id;
    logic [31:0] left;
    logic        last;
  } rsp_t;

  // Holds the timer state and the queue of results still owed by the block.
  class timer_scoreboard;
    logic [31:0] now_t;
    logic [31:0] deadline [16];
    logic [31:0] period_q [16];
    bit          active [16];
    rsp_t        owed [$];
    int          mismatches;

    function void clear();
      now_t = '0;
      mismatches = 0;
      for (int i = 0; i < 16; i++) begin
        deadline[i] = '0;
        period_q[i] = '0;
        active[i] = 0;
      end
    endfunction

    function void push(logic [2:0] k, logic [3:0] id, logic [31:0] l);
      rsp_t r;
      r.kind = k;
      r.id = id;
      r.left = l;
      r.last = 1'b0;
      owed.push_back(r);
    endfunction

    function logic [2:0] arm(logic [3:0] id, logic [31:0] after);
      if (active[id]) return K_REFUSED;
      if ({1'b0, after} > {1'b0, 32'hFFFF_FFFF - now_t}) return K_REFUSED;
      deadline[id] = now_t + after;
      active[id] = 1;
      return K_DONE;
    endfunction

    function void note_request(logic [2:0] op, logic [3:0] id, logic [31:0] dly,
                               logic [31:0] per, logic [31:0] nw);
      logic [2:0]  r;
      logic [31:0] p, d, left;
      int          best, n;
      n = 0;
      if (op == OP_ADVANCE) begin
        now_t = nw;
        while (n < 16) begin
          best = 16;
          for (int i = 0; i < 16; i++)
            if (active[i] && deadline[i] <= nw && (best == 16 || deadline[i] < deadline[best]))
              best = i;
          if (best == 16) break;
          push(K_EXPIRED, best[3:0], '0);
          n++;
          p = period_q[best];
          d = deadline[best];
          if (p == 0 || d >= 32'hFFFF_FFFF - p) active[best] = 0;
          else begin
            d = d + p;
            if (d <= nw) begin
              if (nw == 32'hFFFF_FFFF) begin
                active[best] = 0;
                continue;
              end
              d = nw + 1;
            end
            deadline[best] = d;
          end
        end
        push(K_FINISH, '0, '0);
      end else if (op > OP_ADVANCE) begin
        push(K_REFUSED, id, '0);
      end else if (op == OP_START) begin
        r = arm(id, dly);
        if (r == K_DONE) period_q[id] = per;
        push(r, id, '0);
      end else if (op == OP_STOP) begin
        active[id] = 0;
        push(K_DONE, id, '0);
      end else if (op == OP_AGAIN) begin
        r = K_DONE;
        p = period_q[id];
        if (active[id]) begin
          if (p == 0 || now_t >= 32'hFFFF_FFFF - p) active[id] = 0;
          else deadline[id] = now_t + p;
        end else if (p != 0) r = arm(id, p);
        push(r, id, '0);
      end else begin
        left = '0;
        if (active[id] && deadline[id] > now_t) left = deadline[id] - now_t;
        push(K_REMAIN, id, left);
      end
      owed[$].last = 1'b1;
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = owed.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp kind %0d id %0d left %0d last %0d, got %0d %0d %0d %0d",
                   exp.kind, exp.id, exp.left, exp.last,
                   got.kind, got.id, got.left, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  tds_in_if  req ();
  tds_out_if rsp ();
  timer_scoreboard sb;
  int  idle_cycles;
  bit  hold_off;
  bit  stim_done;

  always #1 clk_i = ~clk_i;

  timer_deadline_scheduler_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req.sink),
    .rsp_o (rsp.source)
  );

  initial begin
    req.valid = 1'b0;
    req.opcode = '0;
    req.timer_id = '0;
    req.delay = '0;
    req.period = '0;
    req.now = '0;
    rsp.ready = 1'b0;
    sb = new();
    sb.clear();
  end

  task automatic send(logic [2:0] op, logic [3:0] id, logic [31:0] dly,
                      logic [31:0] per, logic [31:0] nw);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.timer_id <= id;
    req.delay <= dly;
    req.period <= per;
    req.now <= nw;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(op, id, dly, per, nw);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom_range(0, 60);
    endcase
  endfunction

  logic [31:0] clock_now;

  initial begin
    stim_done = 0;
    hold_off = 0;
    clock_now = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every operation, overflow, ties, unknown opcodes
    send(OP_REMAIN, 4'd0, '0, '0, '0);
    send(OP_START, 4'd0, 32'd5, 32'd0, '0);
    send(OP_START, 4'd0, 32'd5, 32'd0, '0);
    send(OP_START, 4'd1, 32'd5, 32'd3, '0);
    send(OP_START, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send(OP_REMAIN, 4'd15, '0, '0, '0);
    send(OP_START, 4'd2, 32'd2, 32'd100, '0);
    send(OP_AGAIN, 4'd3, '0, '0, '0);
    send(OP_STOP, 4'd4, '0, '0, '0);
    send(OP_ADVANCE, 4'd9, '0, '0, 32'd5);
    send(OP_REMAIN, 4'd1, '0, '0, '0);
    send(OP_AGAIN, 4'd1, '0, '0, '0);
    send(OP_AGAIN, 4'd0, '0, '0, '0);
    send(3'd5, 4'd7, '0, '0, '0);
    send(3'd7, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_ADVANCE, 4'd0, '0, '0, 32'd1000);
    send(OP_ADVANCE, 4'd0, '0, '0, 32'd2);
    send(OP_START, 4'd5, 32'hFFFF_FFFF, 32'd1, '0);
    send(OP_ADVANCE, 4'd0, '0, '0, 32'hFFFF_FFF0);
    send(OP_START, 4'd6, 32'd10, 32'd1, '0);
    send(OP_AGAIN, 4'd2, '0, '0, '0);
    send(OP_ADVANCE, 4'd0, '0, '0, 32'hFFFF_FFFF);
    send(OP_STOP, 4'd15, '0, '0, '0);
    send(OP_ADVANCE, 4'd0, '0, '0, '0);
    for (int i = 0; i < 480; i++) begin
      if (i == 200) hold_off = 1;
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4:
          send(OP_START, 4'($urandom()), $urandom_range(0, 3) == 0 ? pick_time() :
               $urandom_range(0, 30), $urandom_range(0, 2) == 0 ? 32'd0 :
               ($urandom_range(0, 4) == 0 ? pick_time() : $urandom_range(1, 20)), $urandom());
        5, 6: send(OP_STOP, 4'($urandom()), $urandom(), $urandom(), $urandom());
        7, 8: send(OP_AGAIN, 4'($urandom()), $urandom(), $urandom(), $urandom());
        9, 10: send(OP_REMAIN, 4'($urandom()), $urandom(), $urandom(), $urandom());
        11: send(3'($urandom_range(5, 7)), 4'($urandom()), $urandom(), $urandom(), $urandom());
        default: begin
          if ($urandom_range(0, 9) == 0) clock_now = pick_time();
          else clock_now = clock_now + $urandom_range(0, 25);
          send(OP_ADVANCE, 4'($urandom()), $urandom(), $urandom(), clock_now);
        end
      endcase
    end
    req.valid <= 1'b0;
    stim_done = 1;
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready)
      sb.check_result({rsp.kind, rsp.timer_id_out, rsp.time_left, rsp.last});
  end

  // watchdog on cycles without any transfer
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
